FILE: rtl/msb_first_bit_field_unpacker_unit_macros.svh
// ----------------------------------------------------------------------------
// msb_first_bit_field_unpacker_unit_macros.svh
// Assertion helpers shared by the unpacker checker.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_UNPACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_UNPACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFBU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mfbu_pkg.sv
// ----------------------------------------------------------------------------
// mfbu_pkg
// Shared types and constants of the MSB-first bit-field unpacker.
// ----------------------------------------------------------------------------
package mfbu_pkg;

  localparam int WORD_BITS      = 32;
  localparam int VALUE_BITS     = 31;
  localparam int WIDTH_BITS     = 5;
  localparam int AVAIL_BITS     = 6;   // up to 30 leftover + 32 new bits
  localparam int ACC_BITS       = VALUE_BITS + WORD_BITS;
  localparam int DEF_COUNT_BITS = 24;
  localparam int DATA_BITS      = 32;
  localparam int ADDR_BITS      = 3;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIDTH_BITS-1:0] RESET_BITS_PER_VALUE = 5'd8;

  // register indexes (word address bit)
  localparam logic REG_BITS_PER_VALUE = 1'b0;
  localparam logic REG_VALUE_COUNT    = 1'b1;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] bits_per_value;
    logic                  clear_leftover;
  } mfbu_ctrl_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_of_word;
    logic                  last_of_grid;
  } mfbu_result_t;

  localparam int RESULT_BITS = $bits(mfbu_result_t);

endpackage

FILE: rtl/mfbu_fifo.sv
// ----------------------------------------------------------------------------
// mfbu_fifo
// Short first-in first-out queue used between the unpacker stages.
// ----------------------------------------------------------------------------
module mfbu_fifo #(
  parameter int WIDTH = mfbu_pkg::WORD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int IDX = mfbu_pkg::QUEUE_IDX_BITS;
  localparam int CNT = mfbu_pkg::QUEUE_CNT_BITS;

  logic [WIDTH-1:0] mem [mfbu_pkg::QUEUE_DEPTH];
  logic [IDX-1:0]   wr_ptr;
  logic [IDX-1:0]   rd_ptr;
  logic [CNT-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT'(mfbu_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX'(mfbu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX'(mfbu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/mfbu_front.sv
// ----------------------------------------------------------------------------
// mfbu_front
// Configuration registers and input classification: words that cannot
// produce values (zero width or zero count) are taken and dropped.
// ----------------------------------------------------------------------------
module mfbu_front #(
  parameter int COUNT_BITS = mfbu_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mfbu_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mfbu_pkg::DATA_BITS-1:0] pwdata,
  output logic [mfbu_pkg::DATA_BITS-1:0] prdata,
  input  logic                           push,
  input  logic                           q_full,
  output logic                           q_push,
  output mfbu_pkg::mfbu_ctrl_t           ctrl,
  output logic [COUNT_BITS-1:0]          value_count
);

  logic [mfbu_pkg::WIDTH_BITS-1:0] bits_per_value;
  logic                            wr_en;
  logic                            reg_idx;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_value <= mfbu_pkg::RESET_BITS_PER_VALUE;
      value_count    <= '0;
    end else if (wr_en) begin
      if (reg_idx == mfbu_pkg::REG_BITS_PER_VALUE) begin
        bits_per_value <= pwdata[mfbu_pkg::WIDTH_BITS-1:0];
      end else begin
        value_count <= pwdata[COUNT_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == mfbu_pkg::REG_BITS_PER_VALUE) begin
      prdata = mfbu_pkg::DATA_BITS'(bits_per_value);
    end else begin
      prdata = mfbu_pkg::DATA_BITS'(value_count);
    end
  end

  // a width write drops any partial value held by the back end
  assign ctrl.bits_per_value = bits_per_value;
  assign ctrl.clear_leftover = wr_en && (reg_idx == mfbu_pkg::REG_BITS_PER_VALUE);

  assign q_push = push && !q_full && (bits_per_value != '0) && (value_count != '0);

endmodule

FILE: rtl/mfbu_back.sv
// ----------------------------------------------------------------------------
// mfbu_back
// Extraction engine: holds leftover plus current word; while r_full is low
// it slices one value per cycle, popping the next word with its last value.
// ----------------------------------------------------------------------------
module mfbu_back #(
  parameter int COUNT_BITS = mfbu_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mfbu_pkg::mfbu_ctrl_t           ctrl,
  input  logic [COUNT_BITS-1:0]          value_count,
  input  logic                           q_empty,
  input  logic [mfbu_pkg::WORD_BITS-1:0] q_word,
  output logic                           q_pop,
  input  logic                           r_full,
  output logic                           r_push,
  output mfbu_pkg::mfbu_result_t         r_data
);

  localparam int AB = mfbu_pkg::AVAIL_BITS;
  localparam int VB = mfbu_pkg::VALUE_BITS;

  logic [mfbu_pkg::ACC_BITS-1:0] acc;
  logic [AB-1:0]                 avail;
  logic                          loaded;
  logic [COUNT_BITS-1:0]         emitted;

  logic [AB-1:0]                 nb;
  logic [AB-1:0]                 avail_rem;
  logic [mfbu_pkg::ACC_BITS-1:0] shifted;
  logic [VB-1:0]                 vmask;
  logic [COUNT_BITS-1:0]         emitted_next;
  logic                          done;
  logic                          last_word;
  logic                          emit;
  logic                          word_end;
  logic [AB-1:0]                 base_avail;

  assign nb           = AB'(ctrl.bits_per_value);
  assign avail_rem    = avail - nb;
  assign shifted      = acc >> avail_rem;
  assign vmask        = (VB'(1) << ctrl.bits_per_value) - VB'(1);
  assign emitted_next = emitted + 1'b1;
  assign done         = (emitted_next == '0) || (emitted_next >= value_count);
  assign last_word    = done || (avail_rem < nb);

  assign emit       = loaded && !r_full;
  assign word_end   = emit && last_word;
  assign base_avail = word_end ? (done ? '0 : avail_rem) : avail;
  assign q_pop      = (!loaded || word_end) && !q_empty;

  assign r_push              = emit;
  assign r_data.value        = shifted[VB-1:0] & vmask;
  assign r_data.last_of_word = last_word;
  assign r_data.last_of_grid = done;

  // leftover bits sit in the low end of acc; bits above avail are stale
  always_ff @(posedge clk) begin
    if (q_pop) begin
      acc <= {acc[VB-1:0], q_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= 1'b0;
      avail   <= '0;
      emitted <= '0;
    end else if (ctrl.clear_leftover) begin
      avail <= '0;
    end else begin
      if (emit) begin
        emitted <= done ? '0 : emitted_next;
      end
      if (q_pop) begin
        loaded <= 1'b1;
        avail  <= base_avail + AB'(mfbu_pkg::WORD_BITS);
      end else if (word_end) begin
        loaded <= 1'b0;
        avail  <= base_avail;
      end else if (emit) begin
        avail <= avail_rem;
      end
    end
  end

endmodule

FILE: rtl/msb_first_bit_field_unpacker_unit.sv
// Path: an accepted word is registered in the word queue, then in the
//   extraction engine; its values then pass through the result queue.
// Throughput: one value per cycle while the result queue has room, set by
//   the single extraction shifter; a word gives 4 values at 8-bit width.
// Reset: synchronous rst clears queues, leftover bits and value count and
//   sets width 8, count 0; no clearing pass.
// ----------------------------------------------------------------------------
// msb_first_bit_field_unpacker_unit
// Unpacks MSB-first fixed-width unsigned values from a 32-bit word stream.
// ----------------------------------------------------------------------------
module msb_first_bit_field_unpacker_unit #(
  parameter int COUNT_BITS = mfbu_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfbu_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [mfbu_pkg::DATA_BITS-1:0]  pwdata,
  output logic [mfbu_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  // word input
  input  logic                            push,
  output logic                            full,
  input  logic [mfbu_pkg::WORD_BITS-1:0]  packed_word,
  // value output
  output logic                            empty,
  input  logic                            pop,
  output logic [mfbu_pkg::VALUE_BITS-1:0] value,
  output logic                            last_of_word,
  output logic                            last_of_grid
);

  mfbu_pkg::mfbu_ctrl_t            ctrl;
  logic [COUNT_BITS-1:0]           value_count;
  logic                            wq_push;
  logic                            wq_full;
  logic                            wq_empty;
  logic                            wq_pop;
  logic [mfbu_pkg::WORD_BITS-1:0]  wq_word;
  logic                            rq_push;
  logic                            rq_full;
  mfbu_pkg::mfbu_result_t          rq_din;
  mfbu_pkg::mfbu_result_t          rq_dout;

  // the port never inserts wait states
  assign pready = 1'b1;

  // Front: registers, and the decision whether a word reaches the engine.
  // Words that can yield nothing are taken without entering the word queue.
  mfbu_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .push        (push),
    .q_full      (wq_full),
    .q_push      (wq_push),
    .ctrl        (ctrl),
    .value_count (value_count)
  );

  // full is the word queue's full: every input transaction needs a free slot
  assign full = wq_full;

  // Word queue decouples the input side from the engine.
  mfbu_fifo #(
    .WIDTH (mfbu_pkg::WORD_BITS)
  ) u_word_q (
    .clk   (clk),
    .rst   (rst),
    .push  (wq_push),
    .din   (packed_word),
    .full  (wq_full),
    .pop   (wq_pop),
    .dout  (wq_word),
    .empty (wq_empty)
  );

  // Back: slices values, tracks the grid count and flags word/grid ends.
  mfbu_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .value_count (value_count),
    .q_empty     (wq_empty),
    .q_word      (wq_word),
    .q_pop       (wq_pop),
    .r_full      (rq_full),
    .r_push      (rq_push),
    .r_data      (rq_din)
  );

  // Result queue: lets the engine keep going while a value waits for pop.
  mfbu_fifo #(
    .WIDTH (mfbu_pkg::RESULT_BITS)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .din   (rq_din),
    .full  (rq_full),
    .pop   (pop),
    .dout  (rq_dout),
    .empty (empty)
  );

  assign value        = rq_dout.value;
  assign last_of_word = rq_dout.last_of_word;
  assign last_of_grid = rq_dout.last_of_grid;

endmodule

FILE: rtl/mfbu_checker.sv
// ----------------------------------------------------------------------------
// mfbu_checker
// Port-level checks of the unpacker, bound to the top level.
// ----------------------------------------------------------------------------
`include "msb_first_bit_field_unpacker_unit_macros.svh"

module mfbu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            empty,
  input logic                            pop,
  input logic [mfbu_pkg::VALUE_BITS-1:0] value,
  input logic                            last_of_word,
  input logic                            last_of_grid
);

  // nothing is waiting right after reset
  `MFBU_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), empty, "result after reset")

  // the end of a grid always closes the word it came from
  `MFBU_ASSERT_NOW(a_grid_ends_word, clk, rst, !empty && last_of_grid, last_of_word,
    "last_of_grid without last_of_word")

  // right after reset, with no input transaction, the result side stays empty in the next cycle
  `MFBU_ASSERT_NEXT(a_no_spurious_result, clk, rst, $past(rst) && empty && !push, empty,
    "result without input transaction")

  // a stalled result transaction holds
  `MFBU_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop,
    !empty && $stable(value) && $stable(last_of_word) && $stable(last_of_grid),
    "stalled result changed")

endmodule

bind msb_first_bit_field_unpacker_unit mfbu_checker u_mfbu_checker (.*);
